FILE: rtl/gsm_pkg.sv
package gsm_pkg;

    localparam int COL_W      = 10;
    localparam int OUT_W      = 36;
    localparam int H2_W       = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MAX_ROW_NODES_DEF = 1024;
    localparam int SAMPLE_WIDTH_DEF  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_N  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SQ = 2'd2;

    localparam logic MODE_STIFF = 1'b0;
    localparam logic MODE_MASS  = 1'b1;

    localparam logic [COL_W-1:0] GRID_N_RST  = 10'd50;
    localparam logic             MODE_RST    = MODE_STIFF;
    localparam logic [H2_W-1:0]  STEP_SQ_RST = 32'd1717987;

    typedef struct packed {
        logic valid;
        logic last;
        logic mode;
    } t_tag;

endpackage

FILE: rtl/gsm_ram.sv
module gsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/gsm_mass_scale.sv
module gsm_mass_scale #(
    parameter int SUM_W = 36
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  gsm_pkg::t_tag                 i_tag,
    input  logic signed [SUM_W-1:0]       i_stiff,
    input  logic signed [SUM_W-1:0]       i_sum,
    input  logic [gsm_pkg::H2_W-1:0]      i_h2,
    output gsm_pkg::t_tag                 o_tag,
    output logic signed [gsm_pkg::OUT_W-1:0] o_result
);

    import gsm_pkg::*;

    localparam int UW = SUM_W - 2;
    localparam int VW = UW + 1;
    localparam int VH = VW / 2;
    localparam int VL = VW - VH;
    localparam int PW = SUM_W + H2_W + 1;
    localparam int HH = H2_W / 2;
    localparam int CW = (SUM_W > OUT_W) ? SUM_W : OUT_W;

    localparam logic [VW-1:0] RECIP = VW'((64'd1 << VW) / 64'd3);
    localparam logic [VW-1:0] BIAS  = VW'(64'd3 << (UW - 1));
    localparam logic [VW-1:0] HALF  = VW'(64'd1 << (UW - 1));
    localparam logic signed [CW-1:0] OUT_MAX = CW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [CW-1:0] OUT_MIN = -OUT_MAX - CW'(1);

    t_tag r_a_tag, r_b_tag, r_c_tag, r_d_tag, r_e_tag, r_f_tag, r_g_tag;
    logic signed [SUM_W-1:0] r_a_stiff, r_b_stiff, r_c_stiff, r_d_stiff, r_e_stiff, r_f_stiff;
    logic signed [SUM_W-1:0] r_a_sum;
    logic signed [SUM_W+HH:0] r_b_hi, r_b_lo;
    logic [VW-1:0]            r_c_v, r_d_v, r_e_v;
    logic [VW+VL-1:0]         r_d_hi;
    logic [VW+VH-1:0]         r_d_lo;
    logic [VW-1:0]            r_e_q, r_f_q;
    logic signed [OUT_W-1:0]  r_g_res;

    logic signed [SUM_W+HH:0] p_hi, p_lo;
    logic signed [PW-1:0]     prod_c;
    logic signed [UW-1:0]     u_c;
    logic [VW-1:0]            u_ext, v_c;
    logic [VW+VL-1:0]         m_hi;
    logic [VW+VH-1:0]         m_lo;
    logic [2*VW-1:0]          prod_e;
    logic [VW+1:0]            rem_f;
    logic [VW-1:0]            q_f, qs_g;
    logic signed [UW-1:0]     qv_g;
    logic signed [CW-1:0]     sel_g, clamp_g;

    assign p_hi = r_a_sum * $signed({1'b0, i_h2[H2_W-1:HH]});
    assign p_lo = r_a_sum * $signed({1'b0, i_h2[HH-1:0]});

    // floor(s*h2 / 2^32) then floor(/4): drop the low bits
    assign prod_c = (PW'(r_b_hi) <<< HH) + PW'(r_b_lo);
    assign u_c    = prod_c[SUM_W+H2_W-1:H2_W+2];
    assign u_ext  = VW'(u_c);
    assign v_c    = u_ext + BIAS;

    // floor(v/3) by reciprocal, at most one short
    assign m_hi   = r_c_v[VW-1:VH] * RECIP;
    assign m_lo   = r_c_v[VH-1:0] * RECIP;
    assign prod_e = ((2*VW)'(r_d_hi) << VH) + (2*VW)'(r_d_lo);

    assign rem_f  = (VW+2)'(r_e_v) - ((VW+2)'(r_e_q) << 1) - (VW+2)'(r_e_q);
    assign q_f    = r_e_q + VW'(rem_f >= (VW+2)'(3));

    assign qs_g   = r_f_q - HALF;
    assign qv_g   = qs_g[UW-1:0];
    assign sel_g  = (r_f_tag.mode == MODE_MASS) ? CW'(qv_g) : CW'(r_f_stiff);

    always_comb begin
        priority if (sel_g > OUT_MAX) begin
            clamp_g = OUT_MAX;
        end else if (sel_g < OUT_MIN) begin
            clamp_g = OUT_MIN;
        end else begin
            clamp_g = sel_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
            r_b_tag <= '0;
            r_c_tag <= '0;
            r_d_tag <= '0;
            r_e_tag <= '0;
            r_f_tag <= '0;
            r_g_tag <= '0;
        end else if (i_en) begin
            r_a_tag <= i_tag;
            r_b_tag <= r_a_tag;
            r_c_tag <= r_b_tag;
            r_d_tag <= r_c_tag;
            r_e_tag <= r_d_tag;
            r_f_tag <= r_e_tag;
            r_g_tag <= r_f_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_stiff <= i_stiff;
            r_a_sum   <= i_sum;
            r_b_stiff <= r_a_stiff;
            r_b_hi    <= p_hi;
            r_b_lo    <= p_lo;
            r_c_stiff <= r_b_stiff;
            r_c_v     <= v_c;
            r_d_stiff <= r_c_stiff;
            r_d_v     <= r_c_v;
            r_d_hi    <= m_hi;
            r_d_lo    <= m_lo;
            r_e_stiff <= r_d_stiff;
            r_e_v     <= r_d_v;
            r_e_q     <= prod_e[2*VW-1:VW];
            r_f_stiff <= r_e_stiff;
            r_f_q     <= q_f;
            r_g_res   <= clamp_g[OUT_W-1:0];
        end
    end

    assign o_tag    = r_g_tag;
    assign o_result = r_g_res;

endmodule

FILE: rtl/grid_stencil_matvec_core.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_valid / o_stall          i_sample
// output    out        o_valid / i_stall          o_result_value, o_last_result
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One node per cycle while the output is not stalled. A result leaves the output
// register after the transfer of its south-east neighbor passes the s1 and scale
// registers a to g; the mass multiply and the divide by twelve are most of them.
// Reset clears counters, window and pipeline valids; line buffers are not cleared.
// A stall on the output freezes the whole pipeline, line buffer reads included.
module grid_stencil_matvec_core #(
    parameter int MAX_ROW_NODES = gsm_pkg::MAX_ROW_NODES_DEF,
    parameter int SAMPLE_WIDTH  = gsm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [gsm_pkg::OUT_W-1:0]   o_result_value,
    output logic                               o_last_result,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gsm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import gsm_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int SUM_W  = SW + 4;
    localparam int ADDR_W = (MAX_ROW_NODES > 1) ? $clog2(MAX_ROW_NODES) : 1;
    localparam logic [COL_W-1:0] TWO = COL_W'(2);

    logic [COL_W-1:0] r_grid_n;
    logic             r_mode;
    logic [H2_W-1:0]  r_h2;

    logic [COL_W-1:0] r_col, r_row, n_col, n_row;

    logic                 r_s1_valid;
    logic signed [SW-1:0] r_s1_x;
    logic [COL_W-1:0]     r_s1_col, r_s1_row;

    logic                 r_fwd;
    logic signed [SW-1:0] r_fwd_old, r_fwd_new;
    logic signed [SW-1:0] r_win [4];
    logic signed [SW-1:0] r_prev_x;

    logic en, in_acc, cfg_acc;
    logic s1_col_in, s1_left_ok, fwd_hit, emit, mem_we;
    logic [SW-1:0] rd_old, rd_new;
    logic signed [SW-1:0] mem_old, mem_new, up2, up1, left_v;
    logic signed [SUM_W-1:0] e_cn, e_nn, e_nw, e_wn, e_en, e_sn, e_x, stiff, mass;
    t_tag s1_tag, out_tag;

    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;
    assign in_acc      = i_valid && en;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_n <= GRID_N_RST;
            r_mode   <= MODE_RST;
            r_h2     <= STEP_SQ_RST;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_GRID_N:  r_grid_n <= i_cfg_data[COL_W-1:0];
                CFG_MODE:    r_mode   <= i_cfg_data[0];
                CFG_STEP_SQ: r_h2     <= i_cfg_data[H2_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_col >= r_grid_n) begin
            n_col = '0;
            n_row = (r_row >= r_grid_n) ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (en) begin
                r_s1_valid <= in_acc;
            end
        end
    end

    // same entry written by the item ahead while this one reads it
    assign fwd_hit = r_s1_valid && s1_col_in && (r_s1_col == r_col);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_x    <= i_sample;
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_fwd     <= fwd_hit;
            r_fwd_old <= up1;
            r_fwd_new <= r_s1_x;
        end
    end

    gsm_ram #(.WIDTH(SW), .DEPTH(MAX_ROW_NODES)) u_older_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (ADDR_W'(r_s1_col)),
        .i_wdata (up1),
        .i_re    (in_acc),
        .i_raddr (ADDR_W'(r_col)),
        .o_rdata (rd_old)
    );

    gsm_ram #(.WIDTH(SW), .DEPTH(MAX_ROW_NODES)) u_newer_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (ADDR_W'(r_s1_col)),
        .i_wdata (r_s1_x),
        .i_re    (in_acc),
        .i_raddr (ADDR_W'(r_col)),
        .o_rdata (rd_new)
    );

    assign s1_col_in  = int'(r_s1_col) < MAX_ROW_NODES;
    assign s1_left_ok = (r_s1_col != '0) && (int'(r_s1_col) <= MAX_ROW_NODES);
    assign mem_we     = en && r_s1_valid && s1_col_in;

    assign mem_old = r_fwd ? r_fwd_old : $signed(rd_old);
    assign mem_new = r_fwd ? r_fwd_new : $signed(rd_new);
    assign up2     = s1_col_in ? mem_old : '0;
    assign up1     = s1_col_in ? mem_new : '0;
    assign left_v  = s1_left_ok ? r_prev_x : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_win[i] <= '0;
            end
        end else if (en && r_s1_valid) begin
            r_win[1] <= r_win[0];
            r_win[0] <= up2;
            r_win[3] <= r_win[2];
            r_win[2] <= up1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s1_valid) begin
            r_prev_x <= r_s1_x;
        end
    end

    assign e_cn = SUM_W'(r_win[2]);
    assign e_nn = SUM_W'(r_win[0]);
    assign e_nw = SUM_W'(r_win[1]);
    assign e_wn = SUM_W'(r_win[3]);
    assign e_en = SUM_W'(up1);
    assign e_sn = SUM_W'(left_v);
    assign e_x  = SUM_W'(r_s1_x);

    assign stiff = (e_cn <<< 2) - e_nn - e_sn - e_wn - e_en;
    assign mass  = (e_cn <<< 2) + (e_cn <<< 1) + e_nn + e_sn + e_wn + e_en + e_nw + e_x;

    assign emit = r_s1_valid && (r_s1_row >= TWO) && (r_s1_col >= TWO)
               && (r_s1_row <= r_grid_n) && (r_s1_col <= r_grid_n);

    assign s1_tag.valid = emit;
    assign s1_tag.last  = (r_s1_row == r_grid_n) && (r_s1_col == r_grid_n);
    assign s1_tag.mode  = r_mode;

    gsm_mass_scale #(.SUM_W(SUM_W)) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_tag    (s1_tag),
        .i_stiff  (stiff),
        .i_sum    (mass),
        .i_h2     (r_h2),
        .o_tag    (out_tag),
        .o_result (o_result_value)
    );

    assign o_valid       = out_tag.valid;
    assign o_last_result = out_tag.last;

endmodule
